// ===== src/est_pkg.sv =====
// est_pkg: shared sizes, field codes, payload structs and controller/datapath
// command and status types for the endpoint set table
// no dependencies
package est_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int IP_W          = 32;
    localparam int PORT_W        = 16;
    localparam int ENTRY_W       = IP_W + PORT_W;
    localparam int RND_W         = 16;
    localparam int BIT_W         = $clog2(RND_W);
    localparam int MODE_W        = 3;
    localparam int STAT_W        = 3;
    localparam int COUNT_OUT_W   = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PICK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IP_W-1:0]   ip_addr;
        logic [PORT_W-1:0] port_number;
        logic [RND_W-1:0]  random_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   found;
        logic [IP_W-1:0]        picked_ip;
        logic [PORT_W-1:0]      picked_port;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_DIVIDE,
        ST_PICK_RD,
        ST_PICK_DATA,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_INIT,
        DP_SCAN,
        DP_SHIFT_UP,
        DP_SHIFT_DOWN,
        DP_DIVIDE,
        DP_PICK_RD,
        DP_PICK_LATCH
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              take;
        logic              write_head;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              cnt_clear;
        logic              load_out;
        logic [STAT_W-1:0] out_status;
        logic              out_found;
        logic              out_pick;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              count_zero;
        logic              count_full;
        logic              hit;
        logic              walk_end;
        logic              up_end;
        logic              div_last;
        logic              out_free;
    } dp_stat_t;

endpackage

// ===== src/endpoint_set_table_unit.sv =====
// endpoint_set_table_unit: top level of the endpoint set table
// depends on est_pkg, est_ctrl and est_datapath
//
// One request is handled at a time. s_ready is high only while the sequencer
// is idle. A finished result sits in the output register, so the next request
// is taken while it waits. Entries live in a single ram with one registered
// read port, so search, insert and delete walk the stored pairs one per cycle.
// A search or delete that misses walks every stored pair; a search hit stops at
// the match. Insert scans, then moves every entry back one slot and writes the
// head. A duplicate insert stops at the match and an insert on a full table
// ends after the scan. Delete of a stored pair moves the entries behind it
// forward one slot. Pick on an empty table returns empty without dividing;
// otherwise it runs a bit-per-cycle modulo over the 16-bit random word, then
// one ram read. Clear or an unused mode goes straight to the result.
// After each result the sequencer returns to idle before it takes the next
// request, and it holds while the output register is still occupied.
// The store needs no initialization after reset; of the table state only the count is cleared.
module endpoint_set_table_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  est_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output est_pkg::rsp_t  m_data
);
    import est_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    est_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    est_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/est_ram.sv =====
// est_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/est_ctrl.sv =====
// est_ctrl: request sequencer for the endpoint set table
// depends on est_pkg
module est_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  est_pkg::dp_stat_t stat,
    output est_pkg::dp_cmd_t  cmd
);
    import est_pkg::*;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] code_reg, code_next;
    logic              found_reg, found_next;
    logic              pick_out_reg, pick_out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        found_reg    <= found_next;
        pick_out_reg <= pick_out_next;
    end

    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        found_next    = found_reg;
        pick_out_next = pick_out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                code_next     = STAT_OK;
                found_next    = 1'b0;
                pick_out_next = 1'b0;
                case (stat.mode)
                    MODE_INSERT, MODE_DELETE, MODE_SEARCH: begin
                        state_next = ST_SCAN;
                    end
                    MODE_PICK: begin
                        if (stat.count_zero) begin
                            code_next  = STAT_EMPTY;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_DIVIDE;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (stat.hit) begin
                    if (stat.mode == MODE_INSERT) begin
                        code_next  = STAT_DUP;
                        state_next = ST_DONE;
                    end else if (stat.mode == MODE_DELETE) begin
                        found_next = 1'b1;
                        state_next = ST_SHIFT_DOWN;
                    end else begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                end else if (stat.walk_end) begin
                    if (stat.mode == MODE_INSERT) begin
                        if (stat.count_full) begin
                            code_next  = STAT_FULL;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_SHIFT_UP;
                        end
                    end else begin
                        code_next  = STAT_NOTFOUND;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SHIFT_UP: begin
                if (stat.up_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_DOWN: begin
                if (stat.walk_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVIDE: begin
                if (stat.div_last) begin
                    state_next = ST_PICK_RD;
                end
            end
            ST_PICK_RD: begin
                state_next = ST_PICK_DATA;
            end
            ST_PICK_DATA: begin
                pick_out_next = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.op         = DP_IDLE;
        cmd.take       = 1'b0;
        cmd.write_head = 1'b0;
        cmd.cnt_inc    = 1'b0;
        cmd.cnt_dec    = 1'b0;
        cmd.cnt_clear  = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.out_status = code_reg;
        cmd.out_found  = found_reg;
        cmd.out_pick   = pick_out_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_DISPATCH: begin
                cmd.op        = DP_INIT;
                cmd.cnt_clear = (stat.mode == MODE_CLEAR);
            end
            ST_SCAN: begin
                cmd.op = DP_SCAN;
            end
            ST_SHIFT_UP: begin
                cmd.op         = DP_SHIFT_UP;
                cmd.write_head = stat.up_end;
                cmd.cnt_inc    = stat.up_end;
            end
            ST_SHIFT_DOWN: begin
                cmd.op      = DP_SHIFT_DOWN;
                cmd.cnt_dec = stat.walk_end;
            end
            ST_DIVIDE: begin
                cmd.op = DP_DIVIDE;
            end
            ST_PICK_RD: begin
                cmd.op = DP_PICK_RD;
            end
            ST_PICK_DATA: begin
                cmd.op = DP_PICK_LATCH;
            end
            ST_DONE: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd.op = DP_IDLE;
            end
        endcase
    end

endmodule

// ===== src/est_datapath.sv =====
// est_datapath: request register, entry ram walks, modulo unit and result register
// depends on est_pkg and est_ram
module est_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  est_pkg::req_t     s_data,
    input  est_pkg::dp_cmd_t  cmd,
    output est_pkg::dp_stat_t stat,
    output logic              m_valid,
    input  logic              m_ready,
    output est_pkg::rsp_t     m_data
);
    import est_pkg::*;

    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [RND_W-1:0]   rnd_sh_reg, rnd_sh_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [ENTRY_W-1:0] pick_reg, pick_next;
    rsp_t               out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic [ENTRY_W-1:0] key;
    logic               hit;
    logic               idx_lt;
    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     trial_sub;

    est_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign key       = {req_reg.ip_addr, req_reg.port_number};
    assign hit       = pend_reg && (rd_data == key);
    assign idx_lt    = idx_reg < count_reg;
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign trial     = {rem_reg, rnd_sh_reg[RND_W-1]};
    assign trial_sub = trial - {1'b0, count_reg};

    assign stat.mode       = req_reg.mode;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign stat.hit        = hit;
    assign stat.walk_end   = !pend_reg && !idx_lt;
    assign stat.up_end     = !pend_reg && (idx_reg == '0);
    assign stat.div_last   = (bit_reg == BIT_W'(RND_W - 1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        req_next      = req_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        rem_next      = rem_reg;
        rnd_sh_next   = rnd_sh_reg;
        bit_next      = bit_reg;
        pick_next     = pick_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = rd_data;
        case (cmd.op)
            DP_IDLE: begin
                if (cmd.take) begin
                    req_next = s_data;
                end
            end
            DP_INIT: begin
                idx_next    = '0;
                pend_next   = 1'b0;
                rem_next    = '0;
                bit_next    = '0;
                rnd_sh_next = req_reg.random_value;
            end
            DP_SCAN: begin
                if (hit) begin
                    idx_next  = CNT_W'(pend_idx_reg) + CNT_W'(1);
                    pend_next = 1'b0;
                end else if (idx_lt) begin
                    rd_addr       = idx_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            DP_SHIFT_UP: begin
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg + ADDR_W'(1);
                end
                if (idx_reg != '0) begin
                    rd_addr       = idx_dec[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_dec[ADDR_W-1:0];
                    idx_next      = idx_dec;
                end else begin
                    pend_next = 1'b0;
                end
            end
            DP_SHIFT_DOWN: begin
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg - ADDR_W'(1);
                end
                if (idx_lt) begin
                    rd_addr       = idx_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            DP_DIVIDE: begin
                if (trial >= {1'b0, count_reg}) begin
                    rem_next = trial_sub[CNT_W-1:0];
                end else begin
                    rem_next = trial[CNT_W-1:0];
                end
                rnd_sh_next = {rnd_sh_reg[RND_W-2:0], 1'b0};
                bit_next    = bit_reg + BIT_W'(1);
            end
            DP_PICK_RD: begin
                rd_addr = rem_reg[ADDR_W-1:0];
            end
            DP_PICK_LATCH: begin
                pick_next = rd_data;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
        // new pair goes in at the front once the shift has drained
        if (cmd.write_head) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = key;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_clear) begin
            count_next = '0;
        end else if (cmd.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next         = 1'b1;
            out_next.status      = cmd.out_status;
            out_next.entry_count = COUNT_OUT_W'(count_reg);
            out_next.found       = cmd.out_found;
            out_next.picked_ip   = cmd.out_pick ? pick_reg[ENTRY_W-1:PORT_W] : '0;
            out_next.picked_port = cmd.out_pick ? pick_reg[PORT_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        rem_reg      <= rem_next;
        rnd_sh_reg   <= rnd_sh_next;
        bit_reg      <= bit_next;
        pick_reg     <= pick_next;
        out_reg      <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_inc_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> count_reg < CNT_W'(TABLE_ENTRIES))
        else $error("insert completed on a full table");

    a_dec_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> count_reg != '0)
        else $error("delete completed on an empty table");

    a_pick_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_PICK_RD) |-> rem_reg < count_reg)
        else $error("pick position beyond stored entries");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== verif/est_reply_checker.sv =====
// est_reply_checker: keeps its own copy of the endpoint table, predicts the reply
// to every accepted request and compares it field by field with each reply taken
// depends on est_pkg
module est_reply_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  est_pkg::req_t s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  est_pkg::rsp_t m_data,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import est_pkg::*;

    logic [IP_W-1:0]   tbl_ip   [TABLE_ENTRIES];
    logic [PORT_W-1:0] tbl_port [TABLE_ENTRIES];
    int                tbl_count = 0;
    rsp_t              reply_q [$];
    int                errs = 0;

    function automatic int locate(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_ip[i] == ip && tbl_port[i] == port) begin
                return i;
            end
        end
        return tbl_count;
    endfunction

    function automatic rsp_t serve_request(req_t r);
        rsp_t rsp;
        int   pos;
        rsp        = '0;
        rsp.status = STAT_OK;
        pos        = locate(r.ip_addr, r.port_number);
        case (r.mode)
            MODE_INSERT: begin
                if (pos < tbl_count) begin
                    rsp.status = STAT_DUP;
                end else if (tbl_count >= TABLE_ENTRIES) begin
                    rsp.status = STAT_FULL;
                end else begin
                    for (int i = tbl_count; i > 0; i--) begin
                        tbl_ip[i]   = tbl_ip[i-1];
                        tbl_port[i] = tbl_port[i-1];
                    end
                    tbl_ip[0]   = r.ip_addr;
                    tbl_port[0] = r.port_number;
                    tbl_count++;
                end
            end
            MODE_DELETE: begin
                if (pos < tbl_count) begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_ip[i]   = tbl_ip[i+1];
                        tbl_port[i] = tbl_port[i+1];
                    end
                    tbl_count--;
                    rsp.found = 1'b1;
                end else begin
                    rsp.status = STAT_NOTFOUND;
                end
            end
            MODE_SEARCH: begin
                if (pos < tbl_count) begin
                    rsp.found = 1'b1;
                end else begin
                    rsp.status = STAT_NOTFOUND;
                end
            end
            MODE_PICK: begin
                if (tbl_count == 0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    pos             = int'(r.random_value) % tbl_count;
                    rsp.picked_ip   = tbl_ip[pos];
                    rsp.picked_port = tbl_port[pos];
                end
            end
            MODE_CLEAR: begin
                tbl_count = 0;
            end
            default: begin
            end
        endcase
        rsp.entry_count = COUNT_OUT_W'(tbl_count);
        return rsp;
    endfunction

    task automatic check_field(string name, logic [IP_W-1:0] want, logic [IP_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            tbl_count = 0;
            reply_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual 0x%0h",
                             $time, m_data);
                    errs++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", IP_W'(want.status), IP_W'(m_data.status));
                    check_field("entry_count", IP_W'(want.entry_count),
                                IP_W'(m_data.entry_count));
                    check_field("found", IP_W'(want.found), IP_W'(m_data.found));
                    check_field("picked_ip", want.picked_ip, m_data.picked_ip);
                    check_field("picked_port", IP_W'(want.picked_port),
                                IP_W'(m_data.picked_port));
                end
            end
            if (s_valid && s_ready) begin
                reply_q.push_back(serve_request(s_data));
            end
        end
        pending    <= reply_q.size();
        fail_count <= errs;
    end

endmodule

// ===== verif/tb_endpoint_set_table_unit.sv =====
// tb_endpoint_set_table_unit: drives requests into the endpoint set table in
// bursts, stalls the reply side, and reports the verdict from the checker
// depends on est_pkg, endpoint_set_table_unit and est_reply_checker
module tb_endpoint_set_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import est_pkg::*;

    localparam int POOL_N       = 20;
    localparam int RANDOM_ITEMS = 1130;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_CYCLES  = 500;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    int   fail_count;
    int   pending;

    logic [IP_W-1:0]   key_ip   [POOL_N];
    logic [PORT_W-1:0] key_port [POOL_N];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    endpoint_set_table_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    est_reply_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic req_t make_req(logic [MODE_W-1:0] m, logic [IP_W-1:0] ip,
                                      logic [PORT_W-1:0] port, logic [RND_W-1:0] rnd);
        req_t r;
        r.mode         = m;
        r.ip_addr      = ip;
        r.port_number  = port;
        r.random_value = rnd;
        return r;
    endfunction

    // keys often share an address or a port with a neighbor
    task automatic refresh_keys();
        for (int k = 0; k < POOL_N; k++) begin
            key_ip[k]   = $urandom;
            key_port[k] = PORT_W'($urandom);
            if (k > 0 && $urandom_range(0, 3) == 0) begin
                key_ip[k] = key_ip[k-1];
            end else if (k > 0 && $urandom_range(0, 3) == 0) begin
                key_port[k] = key_port[k-1];
            end
        end
    endtask

    // profile 0 fills the table, 1 mixes, 2 drains
    function automatic logic [MODE_W-1:0] pick_mode(int profile);
        int roll;
        int ins_lim;
        int del_lim;
        int srch_lim;
        int pick_lim;
        if ($urandom_range(0, 99) < 3) begin
            return MODE_W'($urandom_range(int'(MODE_CLEAR) + 1, (1 << MODE_W) - 1));
        end
        case (profile)
            0:       begin ins_lim = 65; del_lim = 73; srch_lim = 85; pick_lim = 99; end
            1:       begin ins_lim = 35; del_lim = 60; srch_lim = 78; pick_lim = 97; end
            default: begin ins_lim = 12; del_lim = 62; srch_lim = 78; pick_lim = 99; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_lim)  return MODE_INSERT;
        if (roll < del_lim)  return MODE_DELETE;
        if (roll < srch_lim) return MODE_SEARCH;
        if (roll < pick_lim) return MODE_PICK;
        return MODE_CLEAR;
    endfunction

    function automatic req_t random_req(int profile);
        int                k;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [RND_W-1:0]  rnd;
        k    = $urandom_range(0, POOL_N - 1);
        ip   = key_ip[k];
        port = key_port[k];
        if ($urandom_range(0, 6) == 0) begin
            ip   = $urandom;
            port = PORT_W'($urandom);
        end
        case ($urandom_range(0, 7))
            0:       rnd = '0;
            1:       rnd = '1;
            default: rnd = RND_W'($urandom);
        endcase
        return make_req(pick_mode(profile), ip, port, rnd);
    endfunction

    task automatic send(req_t r);
        s_data  <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        int   useful;
        int   phase_left;
        int   profile;
        int   burst;
        req_t r;
        refresh_keys();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send(make_req(MODE_CLEAR, '0, '0, '0));
        send(make_req(MODE_PICK, '0, '0, '1));
        send(make_req(MODE_SEARCH, '1, '1, '0));
        send(make_req(MODE_DELETE, '1, '1, '0));
        send(make_req(MODE_INSERT, '0, '0, '0));
        send(make_req(MODE_INSERT, '1, '1, '1));
        send(make_req(MODE_INSERT, '0, '0, '1));
        send(make_req(MODE_INSERT, '0, '1, '0));
        send(make_req(MODE_SEARCH, '1, '0, '0));
        send(make_req(MODE_SEARCH, '0, '0, '0));
        send(make_req(MODE_PICK, '0, '0, '0));
        send(make_req(MODE_PICK, '0, '0, '1));
        send(make_req(MODE_PICK, '1, '1, RND_W'(1)));
        send(make_req(MODE_DELETE, '1, '1, '0));
        send(make_req(MODE_DELETE, '0, '0, '0));
        send(make_req(MODE_W'(MODE_CLEAR + 1), '1, '1, '1));
        send(make_req('1, '1, '1, '1));
        send(make_req(MODE_CLEAR, '1, '1, '1));
        send(make_req(MODE_PICK, '1, '1, '1));
        send(make_req(MODE_DELETE, '0, '1, '0));

        useful     = 0;
        phase_left = 0;
        profile    = 2;
        while (useful < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++) begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(30, 90);
                    profile    = (profile + 1) % 3;
                    if ($urandom_range(0, 2) == 0) begin
                        refresh_keys();
                    end
                end
                r = random_req(profile);
                send(r);
                phase_left--;
                if (r.mode <= MODE_CLEAR) begin
                    useful++;
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // reply side stalls on its own pattern, with one long hold-off
    initial begin
        int style;
        int span;
        int cyc;
        bit held;
        cyc  = 0;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(40, 250);
            for (int c = 0; c < span; c++) begin
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((c % 8) < 5);
                endcase
                @(posedge aclk);
                cyc++;
            end
            if (!held && cyc >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== endpoint_set_table_unit.f =====
src/est_pkg.sv
src/est_ram.sv
src/est_ctrl.sv
src/est_datapath.sv
src/endpoint_set_table_unit.sv
verif/est_reply_checker.sv
verif/tb_endpoint_set_table_unit.sv
